// ===== rtl/slcan_line_parser_assert.svh =====
// Assertion macros used by the SLCAN line parser port checker.
`ifndef SLCAN_LINE_PARSER_ASSERT_SVH
`define SLCAN_LINE_PARSER_ASSERT_SVH

// Antecedent implies consequent on the same edge.
`define SLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcan_line_parser: implication check failed");

// Stalled signal must hold on the next edge.
`define SLP_ASSERT_HOLD(label, clk, rst_n, stall, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (stall) |=> $stable(sig)) \
        else $error("slcan_line_parser: stalled value changed");

`endif

// ===== rtl/slp_pkg.sv =====
// Types, constants and decode functions for the SLCAN line parser.
`timescale 1ns / 1ps
package slp_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int NIB_COUNT      = 2 * MAX_DATA_BYTES;
    localparam int PAYLOAD_W      = 64;
    localparam int ID_W           = 29;
    localparam int ID_STD_W       = 11;
    localparam int CNT_W          = 5;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] COUNT_MAX      = 5'd31;
    localparam logic [CNT_W-1:0] ID_NIBS_STD    = 5'd3;
    localparam logic [CNT_W-1:0] ID_NIBS_EXT    = 5'd8;
    localparam logic [3:0]       MAX_DLC        = 4'(MAX_DATA_BYTES);

    // Characters
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_EXT      = 8'h54; // 'T'
    localparam logic [7:0] CHAR_STD      = 8'h74; // 't'
    localparam logic [7:0] CHAR_OPEN     = 8'h4F; // 'O'
    localparam logic [7:0] CHAR_LISTEN   = 8'h4C; // 'L'
    localparam logic [7:0] CHAR_CLOSE    = 8'h43; // 'C'
    localparam logic [7:0] CHAR_VERSION  = 8'h56; // 'V'
    localparam logic [7:0] CHAR_FWVER    = 8'h76; // 'v'
    localparam logic [7:0] CHAR_SERIAL   = 8'h4E; // 'N'
    localparam logic [7:0] CHAR_BAUD_UC  = 8'h53; // 'S'
    localparam logic [7:0] CHAR_BAUD_LC  = 8'h73; // 's'
    localparam logic [7:0] CHAR_STATUS   = 8'h46; // 'F'

    // Command codes
    localparam logic [3:0] CMD_INVALID     = 4'd0;
    localparam logic [3:0] CMD_OPEN        = 4'd1;
    localparam logic [3:0] CMD_LISTEN      = 4'd2;
    localparam logic [3:0] CMD_CLOSE       = 4'd3;
    localparam logic [3:0] CMD_VERSION     = 4'd4;
    localparam logic [3:0] CMD_FWVERSION   = 4'd5;
    localparam logic [3:0] CMD_SERIAL      = 4'd6;
    localparam logic [3:0] CMD_SETBAUD     = 4'd7;
    localparam logic [3:0] CMD_STATUS      = 4'd8;
    localparam logic [3:0] CMD_UNSUPPORTED = 4'd9;
    localparam logic [3:0] CMD_FRAME       = 4'd10;

    // Event kinds passed from front to back
    localparam logic [1:0] EVT_CONTENT = 2'd0;
    localparam logic [1:0] EVT_BREAK   = 2'd1;
    localparam logic [1:0] EVT_END     = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [3:0] nib;
        logic       hex_ok;
    } evt_t;

    typedef struct packed {
        logic [3:0]           cmd_type;
        logic                 frame_found;
        logic                 is_extended;
        logic [ID_W-1:0]      can_id;
        logic [3:0]           data_length;
        logic [PAYLOAD_W-1:0] payload;
    } result_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nib = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.nib = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.nib = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_frame_op(input logic [7:0] c);
        return (c == CHAR_EXT) || (c == CHAR_STD);
    endfunction

    function automatic logic [3:0] command_of(input logic [7:0] c);
        logic [3:0] cmd;
        unique case (c) inside
            CHAR_OPEN:                   cmd = CMD_OPEN;
            CHAR_LISTEN:                 cmd = CMD_LISTEN;
            CHAR_CLOSE:                  cmd = CMD_CLOSE;
            CHAR_VERSION:                cmd = CMD_VERSION;
            CHAR_FWVER:                  cmd = CMD_FWVERSION;
            CHAR_SERIAL:                 cmd = CMD_SERIAL;
            CHAR_BAUD_UC, CHAR_BAUD_LC:  cmd = CMD_SETBAUD;
            CHAR_STATUS:                 cmd = CMD_STATUS;
            default:                     cmd = CMD_UNSUPPORTED;
        endcase
        return cmd;
    endfunction

endpackage

// ===== rtl/slp_front.sv =====
// Front end: classifies each incoming character into a line event.
`timescale 1ns / 1ps
module slp_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_char_code,
    input  logic              s_line_end,
    output logic              evt_valid,
    input  logic              evt_ready,
    output slp_pkg::evt_t     evt
);
    import slp_pkg::*;

    hex_t hex;

    always_comb begin
        hex = hex_decode(s_char_code);
        evt.char_code = s_char_code;
        evt.nib       = hex.nib;
        evt.hex_ok    = hex.ok;
        if (s_line_end) begin
            evt.kind = EVT_END;
        end else if (s_char_code == CHAR_CR || s_char_code == CHAR_LF) begin
            evt.kind = EVT_BREAK;
        end else begin
            evt.kind = EVT_CONTENT;
        end
    end

    assign evt_valid = s_valid;
    assign s_ready   = evt_ready;

endmodule

// ===== rtl/slp_queue.sv =====
// Small event queue between the classifier and the line decoder.
`timescale 1ns / 1ps
module slp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  slp_pkg::evt_t     in_evt,
    output logic              out_valid,
    input  logic              out_ready,
    output slp_pkg::evt_t     out_evt
);
    import slp_pkg::*;

    evt_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg,  count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_evt   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_evt;
        end
    end

endmodule

// ===== rtl/slp_back.sv =====
// Back end: per-line decode state, command resolution and result register.
`timescale 1ns / 1ps
module slp_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            evt_valid,
    output logic                            evt_ready,
    input  slp_pkg::evt_t                   evt,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [3:0]                      m_cmd_type,
    output logic                            m_frame_found,
    output logic                            m_is_extended,
    output logic [slp_pkg::ID_W-1:0]        m_can_id,
    output logic [3:0]                      m_data_length,
    output logic [slp_pkg::PAYLOAD_W-1:0]   m_payload
);
    import slp_pkg::*;

    logic [7:0]           first_char_reg,    first_char_next;
    logic [CNT_W-1:0]     content_count_reg, content_count_next;
    logic [CNT_W-1:0]     pending_reg,       pending_next;
    logic [ID_W-1:0]      id_accum_reg,      id_accum_next;
    logic [3:0]           length_reg,        length_next;
    logic [PAYLOAD_W-1:0] payload_reg,       payload_next;
    logic                 frame_error_reg,   frame_error_next;
    logic                 out_valid_reg,     out_valid_next;
    result_t              out_reg,           out_next;

    logic                 take;
    logic                 out_free;
    logic [CNT_W:0]       flush_sum;
    logic [CNT_W-1:0]     pos;
    logic [7:0]           fc_flushed;
    logic                 err_flushed;
    logic [CNT_W-1:0]     id_nibs;
    logic [CNT_W-1:0]     nib_index;
    logic [CNT_W:0]       need_len;
    logic                 is_ext;
    result_t              res;

    assign out_free  = !out_valid_reg || m_ready;
    assign evt_ready = (evt.kind != EVT_END) || out_free;
    assign take      = evt_valid && evt_ready;

    // Decode of a content character, with held-back breaks folded in first
    always_comb begin
        flush_sum   = {1'b0, content_count_reg} + {1'b0, pending_reg};
        pos         = (flush_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : flush_sum[CNT_W-1:0];
        // a break that leads the line becomes the first character
        fc_flushed  = (pending_reg != '0 && content_count_reg == '0) ? CHAR_CR
                                                                     : first_char_reg;
        err_flushed = frame_error_reg || (pending_reg != '0 && content_count_reg != '0
                                          && is_frame_op(first_char_reg));
        id_nibs     = (fc_flushed == CHAR_EXT) ? ID_NIBS_EXT : ID_NIBS_STD;
        nib_index   = pos - (id_nibs + 5'd2);
    end

    // End of line: resolve the command
    always_comb begin
        is_ext   = (first_char_reg == CHAR_EXT);
        need_len = {1'b0, (is_ext ? ID_NIBS_EXT : ID_NIBS_STD)} + 6'd2
                   + {1'b0, length_reg, 1'b0};
        res      = '0;
        if (content_count_reg != '0) begin
            if (!is_frame_op(first_char_reg)) begin
                res.cmd_type = command_of(first_char_reg);
            end else if (!frame_error_reg && {1'b0, content_count_reg} == need_len) begin
                res.cmd_type    = CMD_FRAME;
                res.frame_found = 1'b1;
                res.is_extended = is_ext;
                res.can_id      = is_ext ? id_accum_reg
                                         : {{(ID_W-ID_STD_W){1'b0}}, id_accum_reg[ID_STD_W-1:0]};
                res.data_length = length_reg;
                res.payload     = payload_reg;
            end
        end
    end

    always_comb begin
        first_char_next    = first_char_reg;
        content_count_next = content_count_reg;
        pending_next       = pending_reg;
        id_accum_next      = id_accum_reg;
        length_next        = length_reg;
        payload_next       = payload_reg;
        frame_error_next   = frame_error_reg;
        out_valid_next     = m_ready ? 1'b0 : out_valid_reg;
        out_next           = out_reg;

        if (take) begin
            case (evt.kind)
                EVT_BREAK: begin
                    if (pending_reg != COUNT_MAX) begin
                        pending_next = pending_reg + 1'b1;
                    end
                end
                EVT_CONTENT: begin
                    pending_next       = '0;
                    first_char_next    = fc_flushed;
                    content_count_next = pos;
                    frame_error_next   = err_flushed;
                    // saturated positions are not decoded
                    if (pos != COUNT_MAX) begin
                        content_count_next = pos + 1'b1;
                        if (pos == '0) begin
                            first_char_next = evt.char_code;
                        end else if (is_frame_op(fc_flushed)) begin
                            if (!evt.hex_ok) begin
                                frame_error_next = 1'b1;
                            end else if (pos <= id_nibs) begin
                                id_accum_next = {id_accum_reg[ID_W-5:0], evt.nib};
                            end else if (pos == id_nibs + 5'd1) begin
                                length_next = evt.nib;
                                if (evt.nib > MAX_DLC) begin
                                    frame_error_next = 1'b1;
                                end
                            end else begin
                                // high nibble of each byte comes first
                                for (int k = 0; k < NIB_COUNT; k++) begin
                                    if (nib_index == CNT_W'(k)) begin
                                        payload_next[8*(k/2) + 4*(1 - k%2) +: 4] = evt.nib;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                    out_valid_next     = 1'b1;
                    out_next           = res;
                    first_char_next    = '0;
                    content_count_next = '0;
                    pending_next       = '0;
                    id_accum_next      = '0;
                    length_next        = '0;
                    payload_next       = '0;
                    frame_error_next   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_char_reg    <= '0;
            content_count_reg <= '0;
            pending_reg       <= '0;
            id_accum_reg      <= '0;
            length_reg        <= '0;
            payload_reg       <= '0;
            frame_error_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            first_char_reg    <= first_char_next;
            content_count_reg <= content_count_next;
            pending_reg       <= pending_next;
            id_accum_reg      <= id_accum_next;
            length_reg        <= length_next;
            payload_reg       <= payload_next;
            frame_error_reg   <= frame_error_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_cmd_type    = out_reg.cmd_type;
    assign m_frame_found = out_reg.frame_found;
    assign m_is_extended = out_reg.is_extended;
    assign m_can_id      = out_reg.can_id;
    assign m_data_length = out_reg.data_length;
    assign m_payload     = out_reg.payload;

endmodule

// ===== rtl/slcan_line_parser.sv =====
// Top level of the SLCAN command line parser.
// SLCAN line parser: takes one ASCII character per transfer on the s_ channel and,
// for each transfer with s_line_end high, returns one decoded command on the m_
// channel (open, listen, close, version, serial, baud, status, unsupported, data
// frame or invalid). Trailing CR/LF are trimmed; t/T frames are checked for hex
// digits, exact length and DLC, then the ID and payload are returned. Throughput
// is one character per clock while the event queue has room; it fills when a
// terminator waits for a busy output register. A character is written into the
// four-entry event queue at its transfer and updates the decode state when the
// back end takes it; a terminator's command is presented from an output register.
// The queue lets input transfers continue while a finished command waits.
`timescale 1ns / 1ps
module slcan_line_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_char_code,
    input  logic                            s_line_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [3:0]                      m_cmd_type,
    output logic                            m_frame_found,
    output logic                            m_is_extended,
    output logic [slp_pkg::ID_W-1:0]        m_can_id,
    output logic [3:0]                      m_data_length,
    output logic [slp_pkg::PAYLOAD_W-1:0]   m_payload
);
    import slp_pkg::*;

    logic fe_valid, fe_ready;
    evt_t fe_evt;
    logic q_valid, q_ready;
    evt_t q_evt;

    slp_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_line_end  (s_line_end),
        .evt_valid   (fe_valid),
        .evt_ready   (fe_ready),
        .evt         (fe_evt)
    );

    slp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_evt    (fe_evt),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_evt   (q_evt)
    );

    slp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .evt_valid     (q_valid),
        .evt_ready     (q_ready),
        .evt           (q_evt),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cmd_type    (m_cmd_type),
        .m_frame_found (m_frame_found),
        .m_is_extended (m_is_extended),
        .m_can_id      (m_can_id),
        .m_data_length (m_data_length),
        .m_payload     (m_payload)
    );

endmodule

// ===== rtl/slp_checker.sv =====
// Port-level checker for the SLCAN line parser, bound to the top level.
`timescale 1ns / 1ps
`include "slcan_line_parser_assert.svh"
module slp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [3:0]                      m_cmd_type,
    input  logic                            m_frame_found,
    input  logic                            m_is_extended,
    input  logic [slp_pkg::ID_W-1:0]        m_can_id,
    input  logic [3:0]                      m_data_length,
    input  logic [slp_pkg::PAYLOAD_W-1:0]   m_payload
);
    import slp_pkg::*;

    logic m_stall;
    logic frame_fields_zero;
    logic frame_flag_ok;
    logic frame_bounds_ok;

    assign m_stall           = m_valid && !m_ready;
    assign frame_fields_zero = !m_is_extended && m_can_id == '0 && m_data_length == '0
                               && m_payload == '0;
    assign frame_flag_ok     = (m_frame_found == (m_cmd_type == CMD_FRAME));
    assign frame_bounds_ok   = (m_data_length <= MAX_DLC)
                               && (m_is_extended || (m_can_id >> ID_STD_W) == '0);

    `SLP_ASSERT_HOLD(a_m_valid_hold, aclk, aresetn, m_stall, m_valid)
    `SLP_ASSERT_HOLD(a_m_cmd_hold, aclk, aresetn, m_stall, m_cmd_type)
    `SLP_ASSERT_IMPLY(a_frame_flag, aclk, aresetn, m_valid, frame_flag_ok)
    `SLP_ASSERT_IMPLY(a_no_frame_zero, aclk, aresetn, m_valid && !m_frame_found, frame_fields_zero)
    `SLP_ASSERT_IMPLY(a_frame_bounds, aclk, aresetn, m_valid && m_frame_found, frame_bounds_ok)

endmodule

bind slcan_line_parser slp_checker u_slp_checker (.*);

// ===== bench/slcan_line_parser_check.sv =====
// Checker for the SLCAN line parser: predicts each decoded command and compares it field by field.
`timescale 1ns / 1ps
module slcan_line_parser_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_char_code,
    input  logic                          s_line_end,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [3:0]                    m_cmd_type,
    input  logic                          m_frame_found,
    input  logic                          m_is_extended,
    input  logic [slp_pkg::ID_W-1:0]      m_can_id,
    input  logic [3:0]                    m_data_length,
    input  logic [slp_pkg::PAYLOAD_W-1:0] m_payload,
    output int                            fail_count,
    output int                            expected_left,
    output int                            commands_checked,
    output int                            frames_seen
);
    import slp_pkg::*;

    // Line decode state, cleared by every terminator
    logic [7:0]  line_first  = '0;
    logic [4:0]  line_count  = '0;
    logic [4:0]  line_breaks = '0;
    logic [31:0] id_acc      = '0;
    logic [3:0]  dlc_digit   = '0;
    logic [63:0] data_acc    = '0;
    logic        line_bad    = 1'b0;

    result_t cmd_q[$];
    int errs    = 0;
    int checked = 0;
    int frames  = 0;

    function automatic logic frame_line();
        return line_first == CHAR_EXT || line_first == CHAR_STD;
    endfunction

    function automatic int id_len();
        return (line_first == CHAR_EXT) ? 8 : 3;
    endfunction

    // Bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic logic [3:0] command_for(input logic [7:0] c);
        case (c)
            CHAR_OPEN:                  return CMD_OPEN;
            CHAR_LISTEN:                return CMD_LISTEN;
            CHAR_CLOSE:                 return CMD_CLOSE;
            CHAR_VERSION:               return CMD_VERSION;
            CHAR_FWVER:                 return CMD_FWVERSION;
            CHAR_SERIAL:                return CMD_SERIAL;
            CHAR_BAUD_UC, CHAR_BAUD_LC: return CMD_SETBAUD;
            CHAR_STATUS:                return CMD_STATUS;
            default:                    return CMD_UNSUPPORTED;
        endcase
    endfunction

    task automatic clear_line();
        line_first  = '0;
        line_count  = '0;
        line_breaks = '0;
        id_acc      = '0;
        dlc_digit   = '0;
        data_acc    = '0;
        line_bad    = 1'b0;
    endtask

    task automatic take_char(input logic [7:0] c);
        logic [4:0] pos;
        logic [4:0] nib;
        int idn;
        int q;
        int sh;
        pos = line_count;
        // positions past saturation are not decoded
        if (pos == COUNT_MAX) return;
        line_count = pos + 5'd1;
        if (pos == 0) begin
            line_first = c;
            return;
        end
        if (!frame_line()) return;
        nib = nibble_of(c);
        if (nib[4]) begin
            line_bad = 1'b1;
            return;
        end
        idn = id_len();
        if (pos <= idn) begin
            id_acc = {id_acc[27:0], nib[3:0]};
        end else if (pos == idn + 1) begin
            dlc_digit = nib[3:0];
            if (nib[3:0] > MAX_DLC) line_bad = 1'b1;
        end else begin
            q = pos - (idn + 2);
            if (q < NIB_COUNT) begin
                sh = 8 * (q / 2) + ((q % 2 == 1) ? 0 : 4);
                data_acc |= 64'(nib[3:0]) << sh;
            end
        end
    endtask

    // Breaks followed by more content count as content.
    task automatic absorb_breaks();
        int total;
        if (line_breaks == 0) return;
        if (line_count == 0) begin
            take_char(CHAR_CR);
            line_breaks = line_breaks - 5'd1;
        end
        if (line_breaks != 0 && frame_line()) line_bad = 1'b1;
        total = int'(line_count) + int'(line_breaks);
        if (total > int'(COUNT_MAX)) total = int'(COUNT_MAX);
        line_count  = 5'(total);
        line_breaks = '0;
    endtask

    function automatic result_t close_line();
        result_t r;
        int need;
        r = '0;
        if (line_count != 0) begin
            if (!frame_line()) begin
                r.cmd_type = command_for(line_first);
            end else begin
                need = id_len() + 2 + 2 * int'(dlc_digit);
                if (!line_bad && int'(line_count) == need) begin
                    r.cmd_type    = CMD_FRAME;
                    r.frame_found = 1'b1;
                    r.is_extended = (line_first == CHAR_EXT);
                    r.can_id      = r.is_extended ? id_acc[28:0] : {18'b0, id_acc[10:0]};
                    r.data_length = dlc_digit;
                    r.payload     = data_acc;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errs++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            clear_line();
            cmd_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_line_end) begin
                    cmd_q.push_back(close_line());
                    clear_line();
                end else if (s_char_code == CHAR_CR || s_char_code == CHAR_LF) begin
                    if (line_breaks != COUNT_MAX) line_breaks = line_breaks + 5'd1;
                end else begin
                    absorb_breaks();
                    take_char(s_char_code);
                end
            end
            if (m_valid && m_ready) begin
                if (cmd_q.size() == 0) begin
                    errs++;
                    $error("unexpected command transfer, cmd_type 0x%0h", m_cmd_type);
                end else begin
                    want = cmd_q.pop_front();
                    checked++;
                    if (want.frame_found) frames++;
                    check_field("cmd_type", 64'(want.cmd_type), 64'(m_cmd_type));
                    check_field("frame_found", 64'(want.frame_found), 64'(m_frame_found));
                    check_field("is_extended", 64'(want.is_extended), 64'(m_is_extended));
                    check_field("can_id", 64'(want.can_id), 64'(m_can_id));
                    check_field("data_length", 64'(want.data_length), 64'(m_data_length));
                    check_field("payload", want.payload, m_payload);
                end
            end
        end
        fail_count       <= errs;
        expected_left    <= cmd_q.size();
        commands_checked <= checked;
        frames_seen      <= frames;
    end

endmodule

// ===== bench/slcan_line_parser_test.sv =====
// Top of the SLCAN line parser testbench: clock, reset, line stimulus and verdict.
`timescale 1ns / 1ps
module slcan_line_parser_test;
    import slp_pkg::*;

    localparam int ITEM_TARGET = 600;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        FLAW_NONE, FLAW_DIGIT, FLAW_SHORT, FLAW_LONG, FLAW_DLC, FLAW_BREAK, FLAW_TRAIL
    } flaw_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_char_code = '0;
    logic                 s_line_end  = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [3:0]           m_cmd_type;
    logic                 m_frame_found;
    logic                 m_is_extended;
    logic [ID_W-1:0]      m_can_id;
    logic [3:0]           m_data_length;
    logic [PAYLOAD_W-1:0] m_payload;

    int   fail_count;
    int   expected_left;
    int   commands_checked;
    int   frames_seen;
    int   cycles     = 0;
    int   chars_sent = 0;
    int   lines_sent = 0;
    logic calm;

    logic [7:0] line_buf[$];

    slcan_line_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_line_end    (s_line_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cmd_type    (m_cmd_type),
        .m_frame_found (m_frame_found),
        .m_is_extended (m_is_extended),
        .m_can_id      (m_can_id),
        .m_data_length (m_data_length),
        .m_payload     (m_payload)
    );

    slcan_line_parser_check u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_line_end       (s_line_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cmd_type       (m_cmd_type),
        .m_frame_found    (m_frame_found),
        .m_is_extended    (m_is_extended),
        .m_can_id         (m_can_id),
        .m_data_length    (m_data_length),
        .m_payload        (m_payload),
        .fail_count       (fail_count),
        .expected_left    (expected_left),
        .commands_checked (commands_checked),
        .frames_seen      (frames_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) cycles <= cycles + 1;

    // One window in three runs with no idling on either side.
    assign calm = ((cycles >> 8) % 3) == 0;

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("slcan_line_parser: mismatch");
        $finish;
    end

    // Result side backpressure
    initial begin
        int stall = 0;
        int r;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    stall = $urandom_range(10, 50);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= (r >= 25);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10) return 8'h30 + 8'(n);
        if ($urandom_range(0, 1) == 1) return 8'h41 + 8'(n) - 8'd10;
        return 8'h61 + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] break_char();
        return ($urandom_range(0, 1) == 1) ? CHAR_LF : CHAR_CR;
    endfunction

    // valid stays high across back-to-back transfers; only lowered for a gap
    task automatic send_item(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_line_end  <= last;
        do @(posedge aclk); while (!s_ready);
        if (!last) chars_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
        // char_code is don't-care on the terminator
        send_item(8'($urandom), 1'b1);
        lines_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic put_breaks(input int n);
        for (int i = 0; i < n; i++) line_buf.push_back(i % 2 ? CHAR_LF : CHAR_CR);
    endtask

    task automatic text_line(input string head, input int mid_breaks,
                             input string tail, input int trail_breaks);
        line_buf = {};
        put_text(head);
        put_breaks(mid_breaks);
        put_text(tail);
        put_breaks(trail_breaks);
        send_line();
    endtask

    task automatic build_frame();
        int    ext;
        int    idn;
        int    dlc;
        int    pos;
        flaw_t flaw;
        line_buf = {};
        ext = $urandom_range(0, 1);
        idn = ext ? 8 : 3;
        dlc = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(0, 8);
        line_buf.push_back(ext ? CHAR_EXT : CHAR_STD);
        for (int i = 0; i < idn; i++) line_buf.push_back(hex_char(4'($urandom)));
        line_buf.push_back(hex_char(4'(dlc)));
        for (int i = 0; i < 2 * dlc; i++) line_buf.push_back(hex_char(4'($urandom)));
        flaw = ($urandom_range(0, 13) > 6) ? FLAW_NONE : flaw_t'($urandom_range(0, 6));
        pos = $urandom_range(1, line_buf.size() - 1);
        case (flaw)
            FLAW_DIGIT: line_buf[pos] = 8'($urandom);
            FLAW_SHORT: void'(line_buf.pop_back());
            FLAW_LONG:  line_buf.push_back(hex_char(4'($urandom)));
            FLAW_DLC: begin
                line_buf[idn + 1] = hex_char(4'($urandom_range(9, 15)));
                repeat ($urandom_range(0, 14)) line_buf.push_back(hex_char(4'($urandom)));
            end
            FLAW_BREAK: line_buf.insert(pos, break_char());
            FLAW_TRAIL: repeat ($urandom_range(1, 3)) line_buf.push_back(break_char());
            default: ;
        endcase
        send_line();
    endtask

    task automatic build_command();
        logic [7:0] ops[12];
        ops = '{CHAR_OPEN, CHAR_LISTEN, CHAR_CLOSE, CHAR_VERSION, CHAR_FWVER, CHAR_SERIAL,
                CHAR_BAUD_UC, CHAR_BAUD_LC, CHAR_STATUS, 8'h72, 8'h52,
                8'h41 + 8'($urandom_range(0, 25))};
        line_buf = {};
        line_buf.push_back(ops[$urandom_range(0, 11)]);
        repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
        if ($urandom_range(0, 2) == 0) line_buf.push_back(break_char());
        send_line();
    endtask

    task automatic build_noise();
        int heavy;
        line_buf = {};
        heavy = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 35)) begin
            if (heavy && $urandom_range(0, 2) == 0) line_buf.push_back(break_char());
            else line_buf.push_back(8'($urandom));
        end
        send_line();
    endtask

    initial begin
        int r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty lines and every command letter
        text_line("", 0, "", 0);
        text_line("", 0, "", 3);
        text_line("O", 0, "", 0);
        text_line("L", 0, "", 0);
        text_line("C", 0, "", 0);
        text_line("V", 0, "", 0);
        text_line("v", 0, "", 0);
        text_line("N", 0, "", 0);
        text_line("S6", 0, "", 0);
        text_line("s031C", 0, "", 0);
        text_line("F", 0, "", 0);
        text_line("r", 0, "", 0);
        text_line("R", 0, "", 0);
        text_line("Z", 0, "", 0);
        // leading break makes the command unsupported; trailing ones are trimmed
        text_line("", 1, "O", 0);
        text_line("O", 0, "", 2);
        // frames at the extremes of ID, DLC and payload
        text_line("t7FF0", 0, "", 0);
        text_line("t0008", 0, "0123456789abcdef", 0);
        text_line("TFFFFFFFF8", 0, "FFFFFFFFFFFFFFFF", 0);
        text_line("T123ABCDE0", 0, "", 0);
        text_line("t12310", 0, "", 2);
        // frame failures
        text_line("t1239", 0, "000000000000000000", 0);
        text_line("t12G0", 0, "", 0);
        text_line("t1231", 0, "", 0);
        text_line("t123", 1, "10", 0);
        // saturation of the length and break counts
        text_line("t0008AAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA", 0, "", 0);
        text_line("t123", 40, "1", 0);
        // null character as ordinary content
        line_buf = {8'h00};
        send_line();
        line_buf = {CHAR_STD, 8'h31, 8'h00, 8'h33, 8'h30};
        send_line();

        while (chars_sent + lines_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            if (r < 6) build_frame();
            else if (r < 8) build_command();
            else build_noise();
        end
        s_valid <= 1'b0;

        // let the predictor count settle past the last terminator
        repeat (2) @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Sent %0d lines (%0d characters); checked %0d commands, %0d of them frames.",
                 lines_sent, chars_sent, commands_checked, frames_seen);
        if (fail_count == 0 && expected_left == 0) begin
            $display("slcan_line_parser: match");
        end else begin
            $display("slcan_line_parser: mismatch");
        end
        $finish;
    end

endmodule

// ===== slcan_line_parser.f =====
+incdir+rtl
rtl/slp_pkg.sv
rtl/slp_front.sv
rtl/slp_queue.sv
rtl/slp_back.sv
rtl/slcan_line_parser.sv
rtl/slp_checker.sv
bench/slcan_line_parser_check.sv
bench/slcan_line_parser_test.sv
